// ===== design/sncalu_pkg.sv =====
// Shared types and codes for the SQL null-aware checked ALU.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sncalu_pkg;

   localparam int DataWidth = 64;
   localparam int DivBits   = 64;
   localparam int NumStages = DivBits + 2;

   localparam logic [3:0] FN_ADD     = 4'd0;
   localparam logic [3:0] FN_SUB     = 4'd1;
   localparam logic [3:0] FN_MUL     = 4'd2;
   localparam logic [3:0] FN_DIV     = 4'd3;
   localparam logic [3:0] FN_EQ      = 4'd4;
   localparam logic [3:0] FN_NE      = 4'd5;
   localparam logic [3:0] FN_LT      = 4'd6;
   localparam logic [3:0] FN_LE      = 4'd7;
   localparam logic [3:0] FN_GT      = 4'd8;
   localparam logic [3:0] FN_GE      = 4'd9;
   localparam logic [3:0] FN_AND     = 4'd10;
   localparam logic [3:0] FN_OR      = 4'd11;
   localparam logic [3:0] FN_NOT     = 4'd12;
   localparam logic [3:0] FN_ISNULL  = 4'd13;
   localparam logic [3:0] FN_NOTNULL = 4'd14;

   localparam logic [1:0] KIND_NULL = 2'd0;
   localparam logic [1:0] KIND_BOOL = 2'd1;
   localparam logic [1:0] KIND_INT  = 2'd2;

   localparam logic [2:0] ST_OK   = 3'd0;
   localparam logic [2:0] ST_NULL = 3'd1;
   localparam logic [2:0] ST_OVF  = 3'd2;
   localparam logic [2:0] ST_DIV0 = 3'd3;
   localparam logic [2:0] ST_KIND = 3'd4;

   localparam logic [DataWidth-1:0] SignBit  = {1'b1, {(DataWidth-1){1'b0}}};
   localparam logic [DataWidth-1:0] MinusOne = {DataWidth{1'b1}};

   // One classified transaction as it waits between front and back.
   typedef struct packed {
      logic                 done;
      logic                 is_mul;
      logic                 is_div;
      logic [1:0]           kind;
      logic [DataWidth-1:0] value;
      logic [2:0]           status;
      logic [DataWidth-1:0] a;
      logic [DataWidth-1:0] b;
   } item_type;

endpackage

`default_nettype wire

// ===== design/sncalu_front.sv =====
// Front classifier: decodes tags and settles every operation except mul and div.
// Depends on sncalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sncalu_front (
   input  wire logic [3:0]                     func,
   input  wire logic [1:0]                     left_kind,
   input  wire logic [sncalu_pkg::DataWidth-1:0] left_value,
   input  wire logic [1:0]                     right_kind,
   input  wire logic [sncalu_pkg::DataWidth-1:0] right_value,
   output sncalu_pkg::item_type                item
);
   import sncalu_pkg::*;

   logic [1:0]           lk, rk;
   logic [DataWidth-1:0] sum, diff;
   logic                 lt, gt, want, decide, res;

   always_comb begin
      lk     = (left_kind == 2'd3) ? KIND_NULL : left_kind;
      rk     = (right_kind == 2'd3) ? KIND_NULL : right_kind;
      sum    = left_value + right_value;
      diff   = left_value - right_value;
      if (lk == KIND_INT) begin
         lt = $signed(left_value) < $signed(right_value);
         gt = $signed(right_value) < $signed(left_value);
      end else begin
         lt = !left_value[0] && right_value[0];
         gt = left_value[0] && !right_value[0];
      end
      want   = (func == FN_OR);
      decide = (lk == KIND_BOOL && left_value[0] == want) ||
               (rk == KIND_BOOL && right_value[0] == want);

      item        = '0;
      item.done   = 1'b1;
      item.kind   = KIND_NULL;
      item.status = ST_KIND;
      item.a      = left_value;
      item.b      = right_value;
      res         = 1'b0;

      case (func)
         FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
            if (lk == KIND_NULL || rk == KIND_NULL) begin
               item.status = ST_NULL;
            end else if (lk != KIND_INT || rk != KIND_INT) begin
               item.status = ST_KIND;
            end else if (func == FN_ADD) begin
               if (left_value[63] == right_value[63] && sum[63] != left_value[63]) begin
                  item.status = ST_OVF;
               end else begin
                  item.kind   = KIND_INT;
                  item.value  = sum;
                  item.status = ST_OK;
               end
            end else if (func == FN_SUB) begin
               if (left_value[63] != right_value[63] && diff[63] != left_value[63]) begin
                  item.status = ST_OVF;
               end else begin
                  item.kind   = KIND_INT;
                  item.value  = diff;
                  item.status = ST_OK;
               end
            end else if (func == FN_MUL) begin
               item.done   = 1'b0;
               item.is_mul = 1'b1;
            end else if (right_value == '0) begin
               item.status = ST_DIV0;
            end else if (left_value == SignBit && right_value == MinusOne) begin
               item.status = ST_OVF;
            end else begin
               item.done   = 1'b0;
               item.is_div = 1'b1;
            end
         end
         FN_EQ, FN_NE, FN_LT, FN_LE, FN_GT, FN_GE: begin
            if (lk == KIND_NULL || rk == KIND_NULL) begin
               item.status = ST_NULL;
            end else if (lk != rk) begin
               item.status = ST_KIND;
            end else begin
               case (func)
                  FN_EQ:   res = !lt && !gt;
                  FN_NE:   res = lt || gt;
                  FN_LT:   res = lt;
                  FN_LE:   res = !gt;
                  FN_GT:   res = gt;
                  default: res = !lt;
               endcase
               item.kind   = KIND_BOOL;
               item.value  = {{(DataWidth-1){1'b0}}, res};
               item.status = ST_OK;
            end
         end
         FN_AND, FN_OR: begin
            if (lk == KIND_INT || rk == KIND_INT) begin
               item.status = ST_KIND;
            end else if (decide) begin
               item.kind   = KIND_BOOL;
               item.value  = {{(DataWidth-1){1'b0}}, want};
               item.status = ST_OK;
            end else if (lk == KIND_NULL || rk == KIND_NULL) begin
               item.status = ST_NULL;
            end else begin
               item.kind   = KIND_BOOL;
               item.value  = {{(DataWidth-1){1'b0}}, !want};
               item.status = ST_OK;
            end
         end
         FN_NOT: begin
            if (lk == KIND_NULL) begin
               item.status = ST_NULL;
            end else if (lk == KIND_INT) begin
               item.status = ST_KIND;
            end else begin
               item.kind   = KIND_BOOL;
               item.value  = {{(DataWidth-1){1'b0}}, !left_value[0]};
               item.status = ST_OK;
            end
         end
         FN_ISNULL, FN_NOTNULL: begin
            item.kind   = KIND_BOOL;
            item.value  = {{(DataWidth-1){1'b0}}, (lk == KIND_NULL) == (func == FN_ISNULL)};
            item.status = ST_OK;
         end
         default: begin
            item.status = ST_KIND;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/sncalu_queue.sv =====
// Four-entry queue of classified transactions between the front and the back.
// Depends on sncalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sncalu_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  sncalu_pkg::item_type      wr_item,
   output logic                      q_full,
   input  wire logic                 rd_en,
   output logic                      q_empty,
   output sncalu_pkg::item_type      rd_item
);
   import sncalu_pkg::*;

   item_type   mem_ff [0:3];
   logic [1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [2:0] count_ff, count_in;

   always_comb begin
      q_full   = (count_ff == 3'd4);
      q_empty  = (count_ff == 3'd0);
      rd_item  = mem_ff[rptr_ff];
      wptr_in  = wptr_ff + 2'(wr_en);
      rptr_in  = rptr_ff + 2'(rd_en);
      count_in = count_ff + 3'(wr_en) - 3'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sncalu_back.sv =====
// Back pipeline: checked 64-bit multiply and restoring divide, one bit per stage.
// Depends on sncalu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sncalu_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   input  sncalu_pkg::item_type      q_item,
   output logic                      q_pop,
   output logic                      out_valid,
   input  wire logic                 out_pop,
   output logic [1:0]                out_kind,
   output logic [sncalu_pkg::DataWidth-1:0] out_value,
   output logic [2:0]                out_status
);
   import sncalu_pkg::*;

   // w0/w1/w2 are scratch words: magnitudes, partial products or the
   // dividend-quotient, divisor and remainder, depending on the operation.
   typedef struct packed {
      logic                 valid;
      logic                 done;
      logic                 is_mul;
      logic                 is_div;
      logic                 neg;
      logic [1:0]           kind;
      logic [DataWidth-1:0] value;
      logic [2:0]           status;
      logic [DataWidth-1:0] w0;
      logic [DataWidth-1:0] w1;
      logic [DataWidth-1:0] w2;
   } stage_type;

   stage_type stage_ff [0:NumStages-1];
   stage_type stage_in [0:NumStages-1];
   logic      adv;

   function automatic logic [DataWidth-1:0] mag(input logic [DataWidth-1:0] x);
      return x[DataWidth-1] ? (~x + 1'b1) : x;
   endfunction

   function automatic stage_type advance(input stage_type x, input int s);
      stage_type        y;
      logic [DataWidth:0] rs;
      logic [33:0]      mid;
      logic             hiz;
      logic             too_big;
      y = x;
      rs = {x.w2, x.w0[DataWidth-1]};
      mid = 34'(x.w0[63:32]) + 34'(x.w1[31:0]) + 34'(x.w2[31:0]);
      hiz = (x.value == '0) && (x.w1[63:32] == '0) && (x.w2[63:32] == '0) &&
            (mid[33:32] == 2'b00);
      too_big = x.neg ? (x.value > SignBit) : (x.value >= SignBit);
      if (x.valid && !x.done) begin
         if (x.is_div && s >= 1 && s <= DivBits) begin
            if (rs >= {1'b0, x.w1}) begin
               y.w2 = rs[DataWidth-1:0] - x.w1;
               y.w0 = {x.w0[DataWidth-2:0], 1'b1};
            end else begin
               y.w2 = rs[DataWidth-1:0];
               y.w0 = {x.w0[DataWidth-2:0], 1'b0};
            end
         end
         if (x.is_div && s == DivBits + 1) begin
            y.done   = 1'b1;
            y.kind   = KIND_INT;
            y.status = ST_OK;
            y.value  = x.neg ? (~x.w0 + 1'b1) : x.w0;
         end
         if (x.is_mul && s == 1) begin
            y.w0    = 64'(x.w0[31:0])  * 64'(x.w1[31:0]);
            y.w1    = 64'(x.w0[31:0])  * 64'(x.w1[63:32]);
            y.w2    = 64'(x.w0[63:32]) * 64'(x.w1[31:0]);
            y.value = 64'(x.w0[63:32]) * 64'(x.w1[63:32]);
         end
         if (x.is_mul && s == 2) begin
            y.value  = {mid[31:0], x.w0[31:0]};
            y.status = hiz ? ST_OK : ST_OVF;
         end
         if (x.is_mul && s == 3) begin
            y.done = 1'b1;
            if (x.status == ST_OVF || too_big) begin
               y.kind   = KIND_NULL;
               y.value  = '0;
               y.status = ST_OVF;
            end else begin
               y.kind   = KIND_INT;
               y.value  = x.neg ? (~x.value + 1'b1) : x.value;
               y.status = ST_OK;
            end
         end
      end
      return y;
   endfunction

   // The whole pipeline moves together unless a result waits unclaimed.
   assign adv   = !stage_ff[NumStages-1].valid || out_pop;
   assign q_pop = adv && !q_empty;

   always_comb begin
      stage_in[0]        = '0;
      stage_in[0].valid  = q_pop;
      stage_in[0].done   = q_item.done;
      stage_in[0].is_mul = q_item.is_mul;
      stage_in[0].is_div = q_item.is_div;
      stage_in[0].neg    = q_item.a[DataWidth-1] ^ q_item.b[DataWidth-1];
      stage_in[0].kind   = q_item.kind;
      stage_in[0].value  = q_item.value;
      stage_in[0].status = q_item.status;
      stage_in[0].w0     = mag(q_item.a);
      stage_in[0].w1     = mag(q_item.b);
      for (int s = 1; s < NumStages; s++) begin
         stage_in[s] = advance(stage_ff[s-1], s);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NumStages; s++) begin
         if (reset) begin
            stage_ff[s].valid <= 1'b0;
         end else if (adv) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign out_valid  = stage_ff[NumStages-1].valid;
   assign out_kind   = stage_ff[NumStages-1].kind;
   assign out_value  = stage_ff[NumStages-1].value;
   assign out_status = stage_ff[NumStages-1].status;

endmodule

`default_nettype wire

// ===== design/sql_null_aware_checked_alu.sv =====
// An accepted push is written to the queue and then crosses every back stage before its result shows on the ports.
// Throughput: one transaction per cycle while no result waits unclaimed; all back stages advance together.
// A waiting result freezes the back; the four-entry queue then fills and raises full.
// Reset is synchronous and active high; it empties the queue and the pipeline.
// Depends on sncalu_pkg, sncalu_front, sncalu_queue and sncalu_back.
`timescale 1ns / 1ps
`default_nettype none

module sql_null_aware_checked_alu (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [3:0]  req_func,
   input  wire logic [1:0]  req_left_kind,
   input  wire logic signed [sncalu_pkg::DataWidth-1:0] req_left_value,
   input  wire logic [1:0]  req_right_kind,
   input  wire logic signed [sncalu_pkg::DataWidth-1:0] req_right_value,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_result_kind,
   output logic signed [sncalu_pkg::DataWidth-1:0] rsp_result_value,
   output logic [2:0]       rsp_status
);
   import sncalu_pkg::*;

   item_type front_item;
   item_type head_item;
   logic     q_full, q_empty, q_pop, out_valid;

   // The front settles every operation except multiply and divide in the
   // same cycle the transaction is pushed; the result rides along.
   sncalu_front u_front (
      .func        (req_func),
      .left_kind   (req_left_kind),
      .left_value  (req_left_value),
      .right_kind  (req_right_kind),
      .right_value (req_right_value),
      .item        (front_item)
   );

   // The queue lets the front keep taking transactions while the back
   // holds a result that has not been popped.
   sncalu_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push && !q_full),
      .wr_item (front_item),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .q_empty (q_empty),
      .rd_item (head_item)
   );

   // Every transaction crosses the full back pipeline so order is kept.
   sncalu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .out_valid  (out_valid),
      .out_pop    (pop),
      .out_kind   (rsp_result_kind),
      .out_value  (rsp_result_value),
      .out_status (rsp_status)
   );

   assign full  = q_full;
   assign empty = !out_valid;

endmodule

`default_nettype wire

// ===== design/sncalu_checker.sv =====
// Port-level checker for the null-aware ALU, bound to the top level.
// Depends on sncalu_pkg and sql_null_aware_checked_alu.
`timescale 1ns / 1ps
`default_nettype none

module sncalu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [1:0]  rsp_result_kind,
   input wire logic [63:0] rsp_result_value,
   input wire logic [2:0]  rsp_status
);
   import sncalu_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result shown right after reset");

   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_result_kind == KIND_NULL) |-> rsp_result_value == '0)
      else $error("null result with nonzero value");

   a_status_kind: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_status == ST_OK) == (rsp_result_kind != KIND_NULL)))
      else $error("status does not match result kind");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_result_value)))
      else $error("waiting result changed");

endmodule

bind sql_null_aware_checked_alu sncalu_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .empty            (empty),
   .pop              (pop),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_result_value (rsp_result_value),
   .rsp_status       (rsp_status)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the SQL null-aware checked ALU.
// Depends on sncalu_pkg and the design sql_null_aware_checked_alu.
`timescale 1ns / 1ps

module tb;
   import sncalu_pkg::*;

   typedef struct packed {
      logic [3:0]  func;
      logic [1:0]  lk;
      logic [63:0] lv;
      logic [1:0]  rk;
      logic [63:0] rv;
   } alu_op_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] value;
      logic [2:0]  status;
   } alu_res_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic [3:0]  req_func = '0;
   logic [1:0]  req_left_kind = '0;
   logic [63:0] req_left_value = '0;
   logic [1:0]  req_right_kind = '0;
   logic [63:0] req_right_value = '0;
   wire         full;
   wire         empty;
   wire [1:0]   rsp_result_kind;
   wire [63:0]  rsp_result_value;
   wire [2:0]   rsp_status;

   sql_null_aware_checked_alu dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_func(req_func), .req_left_kind(req_left_kind),
      .req_left_value(req_left_value), .req_right_kind(req_right_kind),
      .req_right_value(req_right_value), .empty(empty), .pop(pop),
      .rsp_result_kind(rsp_result_kind), .rsp_result_value(rsp_result_value),
      .rsp_status(rsp_status)
   );

   alu_op_type  pending_ops[$];
   alu_res_type expected_results[$];
   int          mismatch_count = 0;
   // Idling is switched off in the last part of the run.
   bit          calm = 1'b0;
   // Long hold-off of the receiver, so that the queue fills and full rises.
   bit          hold_on = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic alu_res_type make_res(logic [1:0] k, logic [63:0] v, logic [2:0] s);
      alu_res_type r;
      r.kind = k;
      r.value = (k == KIND_NULL) ? 64'd0 : v;
      r.status = s;
      return r;
   endfunction

   // Computes the tagged outcome of one transaction under SQL null semantics.
   function automatic alu_res_type eval_sql_op(alu_op_type op);
      logic [1:0]  lk, rk;
      logic signed [63:0]  a, b;
      logic signed [127:0] wide;
      logic [63:0] r;
      logic        lt, gt, res, want;
      lk = (op.lk == 2'd3) ? KIND_NULL : op.lk;
      rk = (op.rk == 2'd3) ? KIND_NULL : op.rk;
      a = op.lv;
      b = op.rv;
      if (op.func <= FN_DIV) begin
         if (lk == KIND_NULL || rk == KIND_NULL) return make_res(KIND_NULL, 0, ST_NULL);
         if (lk != KIND_INT || rk != KIND_INT) return make_res(KIND_NULL, 0, ST_KIND);
         case (op.func)
            FN_ADD: wide = 128'(a) + 128'(b);
            FN_SUB: wide = 128'(a) - 128'(b);
            FN_MUL: wide = 128'(a) * 128'(b);
            default: begin
               if (b == 0) return make_res(KIND_NULL, 0, ST_DIV0);
               if (op.lv == SignBit && op.rv == MinusOne)
                  return make_res(KIND_NULL, 0, ST_OVF);
               wide = 128'(a / b);
            end
         endcase
         if (wide != 128'(signed'(wide[63:0]))) return make_res(KIND_NULL, 0, ST_OVF);
         r = wide[63:0];
         return make_res(KIND_INT, r, ST_OK);
      end
      if (op.func <= FN_GE) begin
         if (lk == KIND_NULL || rk == KIND_NULL) return make_res(KIND_NULL, 0, ST_NULL);
         if (lk != rk) return make_res(KIND_NULL, 0, ST_KIND);
         if (lk == KIND_INT) begin
            lt = a < b;
            gt = a > b;
         end else begin
            lt = !op.lv[0] && op.rv[0];
            gt = op.lv[0] && !op.rv[0];
         end
         case (op.func)
            FN_EQ: res = !lt && !gt;
            FN_NE: res = lt || gt;
            FN_LT: res = lt;
            FN_LE: res = !gt;
            FN_GT: res = gt;
            default: res = !lt;
         endcase
         return make_res(KIND_BOOL, {63'd0, res}, ST_OK);
      end
      if (op.func == FN_AND || op.func == FN_OR) begin
         want = (op.func == FN_OR);
         if (lk == KIND_INT || rk == KIND_INT) return make_res(KIND_NULL, 0, ST_KIND);
         if ((lk == KIND_BOOL && op.lv[0] == want) || (rk == KIND_BOOL && op.rv[0] == want))
            return make_res(KIND_BOOL, {63'd0, want}, ST_OK);
         if (lk == KIND_NULL || rk == KIND_NULL) return make_res(KIND_NULL, 0, ST_NULL);
         return make_res(KIND_BOOL, {63'd0, !want}, ST_OK);
      end
      if (op.func == FN_NOT) begin
         if (lk == KIND_NULL) return make_res(KIND_NULL, 0, ST_NULL);
         if (lk == KIND_INT) return make_res(KIND_NULL, 0, ST_KIND);
         return make_res(KIND_BOOL, {63'd0, !op.lv[0]}, ST_OK);
      end
      if (op.func == FN_ISNULL) return make_res(KIND_BOOL, {63'd0, lk == KIND_NULL}, ST_OK);
      if (op.func == FN_NOTNULL) return make_res(KIND_BOOL, {63'd0, lk != KIND_NULL}, ST_OK);
      return make_res(KIND_NULL, 0, ST_KIND);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic add_op(logic [3:0] f, logic [1:0] lk, logic [63:0] lv,
                         logic [1:0] rk, logic [63:0] rv);
      alu_op_type op;
      op.func = f;
      op.lk = lk;
      op.lv = lv;
      op.rk = rk;
      op.rv = rv;
      pending_ops.push_back(op);
   endtask

   // Operand values favor edges so that overflow and sign cases come up often.
   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 9))
         0: return SignBit;
         1: return ~SignBit;
         2: return MinusOne;
         3: return 64'd0;
         4: return 64'd1;
         5: return {$urandom, $urandom};
         6: return 64'(signed'($urandom_range(0, 200)) - 100);
         7: return {32'd0, $urandom};
         8: return {{32{1'b1}}, $urandom};
         default: return {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
   endfunction

   // Driver: an item is offered from the pending queue, with random idle bursts.
   int send_idle = 0;
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) void'(pending_ops.pop_front());
         if (send_idle > 0) begin
            send_idle <= send_idle - 1;
            push <= 1'b0;
         end else if ((!push || !full) && !calm && $urandom_range(0, 15) == 0) begin
            send_idle <= $urandom_range(1, 10) - 1;
            push <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            push <= 1'b1;
            req_func <= pending_ops[0].func;
            req_left_kind <= pending_ops[0].lk;
            req_left_value <= pending_ops[0].lv;
            req_right_kind <= pending_ops[0].rk;
            req_right_value <= pending_ops[0].rv;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // The expectation is formed when the transaction is accepted.
   always @(posedge clock) begin
      alu_op_type acc;
      if (!reset && push && !full) begin
         acc = {req_func, req_left_kind, req_left_value, req_right_kind, req_right_value};
         expected_results.push_back(eval_sql_op(acc));
      end
   end

   // Monitor: checks each accepted result against the oldest expectation.
   int recv_idle = 0;
   always @(posedge clock) begin
      alu_res_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_result_value, 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_kind !== want.kind)
                  report_mismatch("result_kind", rsp_result_kind, want.kind);
               if (rsp_result_value !== want.value)
                  report_mismatch("result_value", rsp_result_value, want.value);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
            end
         end
         if (hold_on) begin
            pop <= 1'b0;
         end else if (recv_idle > 0) begin
            recv_idle <= recv_idle - 1;
            pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 12) == 0) begin
            recv_idle <= $urandom_range(1, 10) - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Hold the receiver off long enough for the queue to fill and full to rise.
   initial begin
      wait (reset == 1'b0);
      repeat (20) @(posedge clock);
      hold_on <= 1'b1;
      repeat (300) @(posedge clock);
      hold_on <= 1'b0;
   end

   initial begin
      int wait_cycles;
      logic [1:0] lk, rk;
      // Directed part: extremes, every operation and the special cases.
      add_op(FN_ADD, KIND_INT, ~SignBit, KIND_INT, 64'd1);
      add_op(FN_SUB, KIND_INT, SignBit, KIND_INT, 64'd1);
      add_op(FN_MUL, KIND_INT, SignBit, KIND_INT, MinusOne);
      add_op(FN_MUL, KIND_INT, 64'h4000_0000_0000_0000, KIND_INT, MinusOne - 1);
      add_op(FN_DIV, KIND_INT, SignBit, KIND_INT, MinusOne);
      add_op(FN_DIV, KIND_INT, 64'd7, KIND_INT, 64'd0);
      add_op(FN_DIV, KIND_INT, -64'sd7, KIND_INT, 64'd2);
      add_op(FN_ADD, 2'd3, 64'd5, KIND_INT, 64'd5);
      add_op(FN_ADD, KIND_BOOL, 64'd1, KIND_INT, 64'd5);
      add_op(FN_LT, KIND_INT, SignBit, KIND_INT, ~SignBit);
      add_op(FN_GE, KIND_BOOL, 64'd0, KIND_BOOL, 64'd1);
      add_op(FN_EQ, KIND_BOOL, 64'd1, KIND_INT, 64'd1);
      add_op(FN_NE, KIND_NULL, 64'd0, KIND_BOOL, 64'd1);
      add_op(FN_LE, KIND_INT, MinusOne, KIND_INT, MinusOne);
      add_op(FN_GT, KIND_BOOL, 64'd3, KIND_BOOL, 64'd0);
      add_op(FN_AND, KIND_BOOL, 64'd0, KIND_NULL, 64'd0);
      add_op(FN_OR, KIND_NULL, 64'd0, KIND_BOOL, 64'd1);
      add_op(FN_AND, KIND_BOOL, 64'd1, 2'd3, 64'd0);
      add_op(FN_OR, KIND_INT, 64'd1, KIND_BOOL, 64'd0);
      add_op(FN_NOT, KIND_NULL, MinusOne, KIND_INT, 64'd0);
      add_op(FN_NOT, KIND_BOOL, 64'd0, KIND_NULL, 64'd0);
      add_op(FN_ISNULL, 2'd3, 64'd0, KIND_INT, 64'd0);
      add_op(FN_NOTNULL, KIND_INT, MinusOne, KIND_NULL, 64'd0);
      add_op(4'd15, KIND_INT, 64'd1, KIND_INT, 64'd1);
      // Random part: kinds are mostly matched so that most transactions reach
      // the arithmetic and comparison paths.
      for (int i = 0; i < 650; i++) begin
         lk = $urandom_range(0, 3);
         rk = ($urandom_range(0, 3) != 0) ? lk : 2'($urandom_range(0, 3));
         if ($urandom_range(0, 2) != 0 && lk != KIND_BOOL) begin
            lk = KIND_INT;
            rk = KIND_INT;
         end
         add_op(4'($urandom_range(0, 15)), lk, pick_value(), rk, pick_value());
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (pending_ops.size() < 100);
      calm <= 1'b1;
      wait (pending_ops.size() == 0);
      @(posedge clock);
      wait (expected_results.size() == 0);
      wait_cycles = 0;
      while (wait_cycles < NumStages + 10) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb failed");
      $finish;
   end

endmodule
